// ===== design/free_list_node_allocator_defines.svh =====
// Assertion macros for the free-list node allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef FREE_LIST_NODE_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_NODE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FLNA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("free list allocator check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FLNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("free list allocator check failed");

`endif

// ===== design/flna_pkg.sv =====
// Shared types and constants for the free-list node allocator.
// Used by flna_ram and free_list_node_allocator; no dependencies.
`default_nettype none

package flna_pkg;

    localparam int INDEX_W      = 12;
    localparam int INDEX_MAX    = (1 << INDEX_W) - 1;
    localparam int DEF_CAPACITY = 4095;

    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID   = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FULL = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [INDEX_W-1:0] node_index;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] granted_index;
        logic [STAT_W-1:0]  status;
        logic [INDEX_W-1:0] nodes_used;
        logic [INDEX_W-1:0] nodes_free;
    } t_out_item;

    // One node entry: allocated mark and the successor on the free list.
    typedef struct packed {
        logic               used;
        logic [INDEX_W-1:0] link;
    } t_node_word;

endpackage

`default_nettype wire

// ===== design/flna_ram.sv =====
// Node memory: one write port and one read port with registered read data.
// Depends on flna_pkg for the node word type.
`default_nettype none

module flna_ram #(
    parameter int DEPTH  = flna_pkg::DEF_CAPACITY + 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [ADDR_W-1:0]     i_waddr,
    input  wire flna_pkg::t_node_word  i_wdata,
    input  wire logic                  i_re,
    input  wire logic [ADDR_W-1:0]     i_raddr,
    output flna_pkg::t_node_word       o_rdata
);
    import flna_pkg::*;

    t_node_word r_mem [DEPTH];
    t_node_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/free_list_node_allocator.sv =====
// Allocate and free: accept, then one node-memory read feeds the result register.
// Init walks the pool, writing one node entry per cycle.
// A new item is taken only while the sequencer is idle, so allocate and free do not overlap.
// Synchronous active-low reset empties the pool; no clearing pass, an init builds the list.
// Depends on flna_pkg, flna_ram and free_list_node_allocator_defines.svh.
`default_nettype none

module free_list_node_allocator #(
    parameter int CAPACITY = flna_pkg::DEF_CAPACITY
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire flna_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output flna_pkg::t_out_item                  o_out_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [flna_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [flna_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import flna_pkg::*;

    `include "free_list_node_allocator_defines.svh"

    // The largest pool this instance can hold: the parameter, but never more
    // nodes than a 12-bit index can name. Entry 0 is the null node and unused.
    localparam int CAP_LIM_I = (CAPACITY < INDEX_MAX) ? CAPACITY : INDEX_MAX;
    localparam logic [INDEX_W-1:0] CAP_LIM = INDEX_W'(CAP_LIM_I);
    localparam int MEM_DEPTH = CAP_LIM_I + 1;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an item
    localparam logic [1:0] S_EXEC = 2'd1;  // read data present, update and answer
    localparam logic [1:0] S_INIT = 2'd2;  // walking the pool, one node a cycle
    localparam logic [1:0] S_RESP = 2'd3;  // init done, answer with the counts

    logic [1:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [INDEX_W-1:0]  r_node, n_node;
    logic [INDEX_W-1:0]  r_pool_size;
    logic                r_start_full;
    logic [INDEX_W-1:0]  r_pool_cap, n_pool_cap;
    logic [INDEX_W-1:0]  r_head, n_head;
    logic [INDEX_W-1:0]  r_used, n_used;
    logic [INDEX_W-1:0]  r_free, n_free;
    logic [INDEX_W-1:0]  r_walk, n_walk;
    logic                r_fill_used, n_fill_used;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item, n_out_item;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    t_node_word          mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    t_node_word          mem_rdata;

    logic                in_accept;
    logic                slot_free;
    logic [INDEX_W-1:0]  init_cap;

    flna_ram #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Items enter only when the sequencer is idle; the output register is
    // separate, so a waiting result does not hold off the next item.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);

    // A new result may be loaded when the output register is empty or is
    // being taken at this edge.
    assign slot_free = !r_out_valid || !i_out_stall;

    // Pool capacity for init: a zero register selects the full capacity,
    // anything larger is clamped.
    assign init_cap = (r_pool_size == '0 || r_pool_size > CAP_LIM) ? CAP_LIM : r_pool_size;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_node      = r_node;
        n_pool_cap  = r_pool_cap;
        n_head      = r_head;
        n_used      = r_used;
        n_free      = r_free;
        n_walk      = r_walk;
        n_fill_used = r_fill_used;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op   = i_in_item.opcode;
                    n_node = i_in_item.node_index;
                    if (i_in_item.opcode == OP_INIT) begin
                        // Counts and head take their final values now; the
                        // walk only fills the node memory.
                        n_pool_cap  = init_cap;
                        n_fill_used = r_start_full;
                        n_walk      = INDEX_W'(1);
                        if (r_start_full) begin
                            n_used = init_cap;
                            n_free = '0;
                            n_head = '0;
                        end else begin
                            n_used = '0;
                            n_free = init_cap;
                            n_head = (init_cap != '0) ? INDEX_W'(1) : '0;
                        end
                        n_state = (init_cap != '0) ? S_INIT : S_RESP;
                    end else begin
                        // Allocate reads the head's entry, free reads the
                        // entry of the node being returned.
                        mem_re    = 1'b1;
                        mem_raddr = (i_in_item.opcode == OP_ALLOC) ? r_head[ADDR_W-1:0]
                                                                   : i_in_item.node_index[ADDR_W-1:0];
                        n_state   = S_EXEC;
                    end
                end
            end

            S_EXEC: begin
                if (slot_free) begin
                    n_out_item.granted_index = '0;
                    n_out_item.status        = STAT_OK;
                    unique case (r_op)
                        OP_ALLOC: begin
                            if (r_head == '0 || r_head > r_pool_cap || r_free == '0) begin
                                n_out_item.status = STAT_EXHAUSTED;
                            end else begin
                                n_out_item.granted_index = r_head;
                                mem_we    = 1'b1;
                                mem_waddr = r_head[ADDR_W-1:0];
                                mem_wdata = '{used: 1'b1, link: mem_rdata.link};
                                n_head    = mem_rdata.link;
                                n_used    = r_used + INDEX_W'(1);
                                n_free    = r_free - INDEX_W'(1);
                            end
                        end
                        OP_FREE: begin
                            if (r_node == '0 || r_node > r_pool_cap || r_used == '0 ||
                                !mem_rdata.used) begin
                                n_out_item.status = STAT_INVALID;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_node[ADDR_W-1:0];
                                mem_wdata = '{used: 1'b0, link: r_head};
                                n_head    = r_node;
                                n_used    = r_used - INDEX_W'(1);
                                n_free    = r_free + INDEX_W'(1);
                            end
                        end
                        default: begin
                            n_out_item.status = STAT_INVALID;
                        end
                    endcase
                    n_out_item.nodes_used = n_used;
                    n_out_item.nodes_free = n_free;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            S_INIT: begin
                // Either every node is marked used, or the nodes are chained
                // in ascending order with the last one ending the list.
                mem_we    = 1'b1;
                mem_waddr = r_walk[ADDR_W-1:0];
                if (r_fill_used) begin
                    mem_wdata = '{used: 1'b1, link: '0};
                end else begin
                    mem_wdata = '{used: 1'b0,
                                  link: (r_walk < r_pool_cap) ? r_walk + INDEX_W'(1) : '0};
                end
                if (r_walk == r_pool_cap) begin
                    n_state = S_RESP;
                end else begin
                    n_walk = r_walk + INDEX_W'(1);
                end
            end

            S_RESP: begin
                if (slot_free) begin
                    n_out_item.granted_index = '0;
                    n_out_item.status        = STAT_OK;
                    n_out_item.nodes_used    = r_used;
                    n_out_item.nodes_free    = r_free;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pool_size  <= '0;
            r_start_full <= 1'b0;
            r_pool_cap   <= '0;
            r_head       <= '0;
            r_used       <= '0;
            r_free       <= '0;
            r_fill_used  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pool_cap  <= n_pool_cap;
            r_head      <= n_head;
            r_used      <= n_used;
            r_free      <= n_free;
            r_fill_used <= n_fill_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POOL_SIZE:  r_pool_size  <= i_cfg_data[INDEX_W-1:0];
                    CFG_START_FULL: r_start_full <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_node     <= n_node;
        r_walk     <= n_walk;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Every node of the pool is either on the free list or handed out.
    `FLNA_ASSERT_NOW(a_count_sum, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_used} + {1'b0, r_free}) == {1'b0, r_pool_cap})
    // The list is empty exactly when no node is free.
    `FLNA_ASSERT_NOW(a_head_empty, i_clk, i_rst_n, 1'b1, (r_free == '0) == (r_head == '0))
    // The head never points past the pool.
    `FLNA_ASSERT_NOW(a_head_range, i_clk, i_rst_n, 1'b1, r_head <= r_pool_cap)
    // A granted node always comes with an ok status.
    `FLNA_ASSERT_NOW(a_grant_ok, i_clk, i_rst_n,
        o_out_valid && (o_out_item.granted_index != '0), o_out_item.status == STAT_OK)
    // An accepted allocate or free moves the sequencer straight into the execute state.
    `FLNA_ASSERT_NEXT(a_exec_next, i_clk, i_rst_n,
        in_accept && (i_in_item.opcode != OP_INIT), r_state == S_EXEC)

endmodule

`default_nettype wire
